FILE: rtl/mbbr_pkg.sv
`default_nettype none

package mbbr_pkg;

    // Default coordinate width: signed Q8.8.
    localparam int COORD_BITS_DEF = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // an input transfer completes this cycle
        logic sqrt_start;  // load the greatest square into the root unit
        logic publish;     // load the result register and clear the mesh state
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fold_done;   // the last vertex has been folded into the state
        logic root_done;   // the root unit holds a finished result
        logic out_free;    // the result register can take a new result
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/mbbr_isqrt.sv
`default_nettype none

module mbbr_isqrt #(
    parameter int COORD_BITS = mbbr_pkg::COORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [2*COORD_BITS-1:0]   i_operand,
    output logic                           o_done,
    output logic [COORD_BITS-1:0]          o_root
);

    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int REM_BITS = COORD_BITS + 2;
    localparam int CNT_BITS = $clog2(COORD_BITS);

    logic [REM_BITS-1:0]   r_rem;
    logic [REM_BITS-1:0]   n_rem;
    logic [COORD_BITS-1:0] r_root;
    logic [COORD_BITS-1:0] n_root;
    logic [SQ_BITS-1:0]    r_opnd;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [REM_BITS+1:0]   w_rem_sh;
    logic [REM_BITS+1:0]   w_trial;
    logic [REM_BITS+1:0]   w_diff;

    // One root bit per cycle: bring down the next two operand bits and try
    // to subtract four times the partial root plus one.
    always_comb begin
        w_rem_sh = {r_rem, r_opnd[SQ_BITS-1 -: 2]};
        w_trial  = {2'b00, r_root, 2'b01};
        w_diff   = w_rem_sh - w_trial;
        if (w_rem_sh >= w_trial) begin
            n_rem  = w_diff[REM_BITS-1:0];
            n_root = {r_root[COORD_BITS-2:0], 1'b1};
        end else begin
            n_rem  = w_rem_sh[REM_BITS-1:0];
            n_root = {r_root[COORD_BITS-2:0], 1'b0};
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == '0)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    // Remainder, partial root and operand shifter.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_opnd <= i_operand;
            r_cnt  <= CNT_BITS'(COORD_BITS - 1);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_opnd <= {r_opnd[SQ_BITS-3:0], 2'b00};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: rtl/mbbr_datapath.sv
`default_nettype none

module mbbr_datapath #(
    parameter int COORD_BITS = mbbr_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mbbr_pkg::t_cmd                i_cmd,
    output mbbr_pkg::t_status                  o_status,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_x,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_y,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_z,
    input  wire logic                          i_last_vertex,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic signed [COORD_BITS-1:0]       o_min_x,
    output logic signed [COORD_BITS-1:0]       o_min_y,
    output logic signed [COORD_BITS-1:0]       o_min_z,
    output logic [COORD_BITS-2:0]              o_max_x,
    output logic [COORD_BITS-2:0]              o_max_y,
    output logic [COORD_BITS-2:0]              o_max_z,
    output logic [COORD_BITS-1:0]              o_extent_x,
    output logic [COORD_BITS-1:0]              o_extent_y,
    output logic [COORD_BITS-1:0]              o_extent_z,
    output logic [COORD_BITS-1:0]              o_radius
);

    localparam int CB      = COORD_BITS;
    localparam int SQ_BITS = 2 * COORD_BITS;

    // Stage 1: captured vertex.
    logic signed [CB-1:0] r_p1_x, r_p1_y, r_p1_z;
    logic                 r_p1_valid, r_p1_last;

    // Stage 2: squared coordinates.
    logic [SQ_BITS-1:0]   r_sq_x, r_sq_y, r_sq_z;
    logic                 r_p2_valid, r_p2_last;
    logic                 r_p3_last;

    // Running mesh state.
    logic signed [CB-1:0] r_min_x, r_min_y, r_min_z;
    logic [CB-2:0]        r_max_x, r_max_y, r_max_z;
    logic [SQ_BITS-1:0]   r_best;

    // Result register.
    logic                 r_out_valid;
    logic signed [CB-1:0] r_o_min_x, r_o_min_y, r_o_min_z;
    logic [CB-2:0]        r_o_max_x, r_o_max_y, r_o_max_z;
    logic [CB-1:0]        r_o_ext_x, r_o_ext_y, r_o_ext_z;
    logic [CB-1:0]        r_o_radius;

    logic [CB-1:0]        w_abs_x, w_abs_y, w_abs_z;
    logic [SQ_BITS-1:0]   w_sum;
    logic                 w_root_done;
    logic [CB-1:0]        w_root;

    // Magnitudes; the most negative value maps to its true magnitude.
    assign w_abs_x = r_p1_x[CB-1] ? (CB'(0) - CB'(r_p1_x)) : CB'(r_p1_x);
    assign w_abs_y = r_p1_y[CB-1] ? (CB'(0) - CB'(r_p1_y)) : CB'(r_p1_y);
    assign w_abs_z = r_p1_z[CB-1] ? (CB'(0) - CB'(r_p1_z)) : CB'(r_p1_z);

    // The sum of three squares cannot overflow twice the coordinate width.
    assign w_sum = r_sq_x + r_sq_y + r_sq_z;

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p1_last  <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p2_last  <= 1'b0;
            r_p3_last  <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.accept;
            r_p1_last  <= i_cmd.accept && i_last_vertex;
            r_p2_valid <= r_p1_valid;
            r_p2_last  <= r_p1_valid && r_p1_last;
            r_p3_last  <= r_p2_valid && r_p2_last;
        end
    end

    // Vertex capture and squaring.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p1_x <= i_coord_x;
            r_p1_y <= i_coord_y;
            r_p1_z <= i_coord_z;
        end
        if (r_p1_valid) begin
            r_sq_x <= w_abs_x * w_abs_x;
            r_sq_y <= w_abs_y * w_abs_y;
            r_sq_z <= w_abs_z * w_abs_z;
        end
    end

    // Running box and greatest square, cleared once a result is published.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.publish) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_min_z <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
            r_max_z <= '0;
            r_best  <= '0;
        end else begin
            if (r_p1_valid) begin
                if (r_p1_x < r_min_x) r_min_x <= r_p1_x;
                if (r_p1_y < r_min_y) r_min_y <= r_p1_y;
                if (r_p1_z < r_min_z) r_min_z <= r_p1_z;
                if (!r_p1_x[CB-1] && (r_p1_x[CB-2:0] > r_max_x)) r_max_x <= r_p1_x[CB-2:0];
                if (!r_p1_y[CB-1] && (r_p1_y[CB-2:0] > r_max_y)) r_max_y <= r_p1_y[CB-2:0];
                if (!r_p1_z[CB-1] && (r_p1_z[CB-2:0] > r_max_z)) r_max_z <= r_p1_z[CB-2:0];
            end
            if (r_p2_valid && (w_sum > r_best)) begin
                r_best <= w_sum;
            end
        end
    end

    // Square root of the greatest squared distance.
    mbbr_isqrt #(
        .COORD_BITS(COORD_BITS)
    ) u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.sqrt_start),
        .i_operand (r_best),
        .o_done    (w_root_done),
        .o_root    (w_root)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_o_min_x  <= r_min_x;
            r_o_min_y  <= r_min_y;
            r_o_min_z  <= r_min_z;
            r_o_max_x  <= r_max_x;
            r_o_max_y  <= r_max_y;
            r_o_max_z  <= r_max_z;
            r_o_ext_x  <= {1'b0, r_max_x} - CB'(r_min_x);
            r_o_ext_y  <= {1'b0, r_max_y} - CB'(r_min_y);
            r_o_ext_z  <= {1'b0, r_max_z} - CB'(r_min_z);
            r_o_radius <= w_root;
        end
    end

    assign o_status.fold_done = r_p3_last;
    assign o_status.root_done = w_root_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_min_x     = r_o_min_x;
    assign o_min_y     = r_o_min_y;
    assign o_min_z     = r_o_min_z;
    assign o_max_x     = r_o_max_x;
    assign o_max_y     = r_o_max_y;
    assign o_max_z     = r_o_max_z;
    assign o_extent_x  = r_o_ext_x;
    assign o_extent_y  = r_o_ext_y;
    assign o_extent_z  = r_o_ext_z;
    assign o_radius    = r_o_radius;

endmodule

`default_nettype wire

FILE: rtl/mbbr_ctrl.sv
`default_nettype none

module mbbr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_last_vertex,
    output logic                    o_in_ready,
    input  wire mbbr_pkg::t_status  i_status,
    output mbbr_pkg::t_cmd          o_cmd
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_DRAIN = 3'b010,
        ST_SQRT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.sqrt_start = 1'b0;
        o_cmd.publish    = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_last_vertex) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_status.fold_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // The start that entered this state has already cleared the root unit's done flag.
                if (i_status.root_done && i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mesh_bounding_box_radius.sv
`default_nettype none

// Bounding box and bounding radius of a streamed mesh.
//
// Input channel (i_in_valid / o_in_ready): one vertex per transfer, signed
// Q8.8 coordinates, with i_last_vertex set on the final vertex of a mesh.
// Within a mesh a vertex is taken every cycle. After the last vertex the
// input stays stalled until the radius is done: the pipeline folds the
// vertex in, the controller starts the root unit, the square root yields
// one root bit per cycle, and then the result register is loaded, which
// opens the input again for the next mesh.
// Output channel (o_out_valid / i_out_ready): one result per mesh with the
// box corners, the per-axis extent and the floor square root of the greatest
// squared origin distance. The result sits in its own register, so the next
// mesh streams in while it waits; if a new result is done while the old one
// is still not taken, the block holds it and keeps the input stalled.
// The box always contains the origin. Reset clears the running state and
// leaves the output channel empty.

module mesh_bounding_box_radius #(
    parameter int COORD_BITS = mbbr_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_x,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_y,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_z,
    input  wire logic                          i_last_vertex,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]       o_min_x,
    output logic signed [COORD_BITS-1:0]       o_min_y,
    output logic signed [COORD_BITS-1:0]       o_min_z,
    output logic [COORD_BITS-2:0]              o_max_x,
    output logic [COORD_BITS-2:0]              o_max_y,
    output logic [COORD_BITS-2:0]              o_max_z,
    output logic [COORD_BITS-1:0]              o_extent_x,
    output logic [COORD_BITS-1:0]              o_extent_y,
    output logic [COORD_BITS-1:0]              o_extent_z,
    output logic [COORD_BITS-1:0]              o_radius
);

    mbbr_pkg::t_cmd    w_cmd;
    mbbr_pkg::t_status w_status;

    // Sequencing of vertex intake, root and result.
    mbbr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_vertex (i_last_vertex),
        .o_in_ready    (o_in_ready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    // Running box, squares, root unit and result register.
    mbbr_datapath #(
        .COORD_BITS(COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_last_vertex (i_last_vertex),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_min_x       (o_min_x),
        .o_min_y       (o_min_y),
        .o_min_z       (o_min_z),
        .o_max_x       (o_max_x),
        .o_max_y       (o_max_y),
        .o_max_z       (o_max_z),
        .o_extent_x    (o_extent_x),
        .o_extent_y    (o_extent_y),
        .o_extent_z    (o_extent_z),
        .o_radius      (o_radius)
    );

    // The last vertex of a mesh closes the input until its result is loaded.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_vertex) |=> !o_in_ready)
        else $error("input still open after last vertex");

    // Folding the last vertex never overlaps with new vertex intake.
    a_fold_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.fold_done |-> !o_in_ready)
        else $error("vertex intake during final fold");

    // A result is only published into a free result register.
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> (w_status.out_free && w_status.root_done))
        else $error("result published while register busy or root unfinished");

    // A published result shows up on the output channel.
    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |=> o_out_valid)
        else $error("published result not presented");

endmodule

`default_nettype wire
